@@ design/tsyn_pkg.sv @@
package tsyn_pkg;

  localparam logic [31:0] IP_WORD0          = 32'h4500_002C;
  localparam logic [15:0] IP_TTL_PROTO      = 16'h6406;
  localparam logic [31:0] TCP_OFF_FLAGS_WIN = 32'h6002_8000;
  localparam logic [31:0] TCP_MSS_OPT       = 32'h0204_0578;
  localparam logic [15:0] ID_LIMIT          = 16'd65000;
  localparam logic [15:0] ID_MAX            = 16'd65001;
  localparam logic [3:0]  LAST_IDX          = 4'd10;

  // fixed 16-bit terms of each checksum, pre-added
  localparam logic [19:0] IP_CSUM_BASE  = 20'h0_A932;
  localparam logic [19:0] TCP_CSUM_BASE = 20'h0_E79C;

  typedef struct packed {
    logic [31:0] dest_addr;
    logic [31:0] src_addr;
    logic [15:0] dest_port;
    logic [15:0] src_port;
    logic [31:0] seq_value;
    logic [15:0] ident;
    logic [17:0] addr_sum;
  } hdr_req_t;

  function automatic logic [15:0] csum_fold(input logic [19:0] sum);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {13'd0, sum[19:16]} + {1'b0, sum[15:0]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return ~s2[15:0];
  endfunction

endpackage

@@ design/tsyn_if.sv @@
interface tsyn_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_addr;
  logic [31:0] src_addr;
  logic [15:0] dest_port;
  logic [8:0]  src_port_offset;
  logic [31:0] seq_value;

  modport source (output valid, dest_addr, src_addr, dest_port, src_port_offset, seq_value,
                  input ready);
  modport sink (input valid, dest_addr, src_addr, dest_port, src_port_offset, seq_value,
                output ready);
endinterface

interface tsyn_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic [3:0]  word_index;
  logic        last_word;

  modport source (output valid, header_word, word_index, last_word, input ready);
  modport sink (input valid, header_word, word_index, last_word, output ready);
endinterface

interface tsyn_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/tsyn_hdr_out.sv @@
module tsyn_hdr_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  tsyn_pkg::hdr_req_t req,
  output logic              take,
  tsyn_word_if.source       out_word
);
  import tsyn_pkg::*;

  logic        valid_r;
  logic [3:0]  idx_r;
  logic [3:0]  idx_nxt;
  logic [31:0] dst_r;
  logic [31:0] src_r;
  logic [15:0] dport_r;
  logic [15:0] sport_r;
  logic [31:0] seq_r;
  logic [15:0] id_r;
  logic [15:0] ip_csum_r;
  logic [15:0] tcp_csum_r;
  logic [19:0] ip_sum;
  logic [19:0] tcp_sum;
  logic        fire;
  logic        last;

  assign fire = out_word.valid && out_word.ready;
  assign last = (idx_r == LAST_IDX);
  assign take = req_valid && (!valid_r || (fire && last));

  assign ip_sum = {2'd0, req.addr_sum} + {4'd0, req.ident} + IP_CSUM_BASE;
  assign tcp_sum = {2'd0, req.addr_sum} + {4'd0, req.src_port} + {4'd0, req.dest_port}
                 + {4'd0, req.seq_value[31:16]} + {4'd0, req.seq_value[15:0]}
                 + TCP_CSUM_BASE;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = 4'd0;
    end else if (fire && !last) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else begin
      idx_r <= idx_nxt;
      if (take) begin
        valid_r <= 1'b1;
      end else if (fire && last) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dst_r      <= req.dest_addr;
      src_r      <= req.src_addr;
      dport_r    <= req.dest_port;
      sport_r    <= req.src_port;
      seq_r      <= req.seq_value;
      id_r       <= req.ident;
      ip_csum_r  <= csum_fold(ip_sum);
      tcp_csum_r <= csum_fold(tcp_sum);
    end
  end

  assign out_word.valid      = valid_r;
  assign out_word.word_index = idx_r;
  assign out_word.last_word  = last;

  always_comb begin
    case (idx_r)
      4'd0:    out_word.header_word = IP_WORD0;
      4'd1:    out_word.header_word = {id_r, 16'd0};
      4'd2:    out_word.header_word = {IP_TTL_PROTO, ip_csum_r};
      4'd3:    out_word.header_word = src_r;
      4'd4:    out_word.header_word = dst_r;
      4'd5:    out_word.header_word = {sport_r, dport_r};
      4'd6:    out_word.header_word = seq_r;
      4'd8:    out_word.header_word = TCP_OFF_FLAGS_WIN;
      4'd9:    out_word.header_word = {tcp_csum_r, 16'd0};
      4'd10:   out_word.header_word = TCP_MSS_OPT;
      default: out_word.header_word = 32'd0;
    endcase
  end

endmodule

@@ design/tcp_syn_packet_builder_core.sv @@
// Builds a 44-byte IPv4+TCP SYN probe header for each accepted request and sends it as
// eleven 32-bit words, first wire byte in bits 31..24, word_index 0 to 10, last_word on
// word 10. The IP identification comes from an internal counter that runs 1..65001 and
// wraps back to 1. A request is taken into an input register, both checksums are formed
// on its way into the output register, and the words then leave at one per cycle while
// out_word.ready is high. The word sequencer sets the request rate, one request per header
// sent, and the next request is already held while the current header drains.
// An accepted request passes the input register, then the output register, before its first
// word leaves. source_port_base is written through cfg_wr, which is always ready.
module tcp_syn_packet_builder_core (
  input  logic        clk,
  input  logic        rst_n,
  tsyn_req_if.sink    in_req,
  tsyn_word_if.source out_word,
  tsyn_cfg_if.sink    cfg_wr
);
  import tsyn_pkg::*;

  logic [15:0] base_r;
  logic [15:0] ident_r;
  logic [15:0] ident_nxt;
  logic        s1_valid_r;
  hdr_req_t    s1_r;
  logic        take;
  logic        in_fire;

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = !s1_valid_r || take;
  assign in_fire      = in_req.valid && in_req.ready;

  always_comb begin
    ident_nxt = ((ident_r > ID_LIMIT) ? 16'd0 : ident_r) + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= 16'd0;
      ident_r    <= 16'd0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        base_r <= cfg_wr.data;
      end
      if (in_fire) begin
        ident_r <= ident_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.dest_addr <= in_req.dest_addr;
      s1_r.src_addr  <= in_req.src_addr;
      s1_r.dest_port <= in_req.dest_port;
      s1_r.src_port  <= base_r + {7'd0, in_req.src_port_offset};
      s1_r.seq_value <= in_req.seq_value;
      s1_r.ident     <= ident_nxt;
      s1_r.addr_sum  <= {2'd0, in_req.src_addr[31:16]} + {2'd0, in_req.src_addr[15:0]}
                      + {2'd0, in_req.dest_addr[31:16]} + {2'd0, in_req.dest_addr[15:0]};
    end
  end

  tsyn_hdr_out u_hdr_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s1_valid_r),
    .req       (s1_r),
    .take      (take),
    .out_word  (out_word)
  );

  a_ident_range: assert property (@(posedge clk) disable iff (!rst_n)
    ident_r <= ID_MAX)
    else $error("ident counter out of range");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |-> !in_req.ready)
    else $error("request taken while input register full");

  a_last_on_ten: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> (out_word.last_word == (out_word.word_index == LAST_IDX)))
    else $error("last_word not on final word");

  a_take_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.ready && out_word.last_word && s1_valid_r)
      |=> (out_word.valid && out_word.word_index == 4'd0))
    else $error("queued request not started after last word");

endmodule
